// ===== hw/rtl/rfbw_pkg.sv =====
package rfbw_pkg;

	// Field widths of the input and result items.
	localparam int MODE_W   = 2;
	localparam int RECT_XY_W = 12;
	localparam int RECT_WH_W = 13;
	localparam int PIXEL_W  = 32;
	localparam int MASK_W   = 8;
	localparam int ADDR_W   = 24;
	localparam int COLOR_W  = 8;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int BPP_W      = 6;
	localparam int MAX_W      = 16;
	localparam int SHIFT_W    = 5;
	localparam int FW_W       = 13;

	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_idx_t REG_BPP         = 3'd0;
	localparam cfg_idx_t REG_RED_MAX     = 3'd1;
	localparam cfg_idx_t REG_GREEN_MAX   = 3'd2;
	localparam cfg_idx_t REG_BLUE_MAX    = 3'd3;
	localparam cfg_idx_t REG_RED_SHIFT   = 3'd4;
	localparam cfg_idx_t REG_GREEN_SHIFT = 3'd5;
	localparam cfg_idx_t REG_BLUE_SHIFT  = 3'd6;
	localparam cfg_idx_t REG_FRAME_WIDTH = 3'd7;

	// Item modes.
	localparam logic [MODE_W-1:0] MODE_RAW    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CURSOR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PIXEL  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_MASK   = 2'd3;

	localparam logic [BPP_W-1:0] BPP_32 = 6'd32;
	localparam logic [BPP_W-1:0] BPP_16 = 6'd16;

	localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [COLOR_W-1:0] ALPHA_CLEAR  = 8'd0;

	// Scaling divider: an 8-bit quotient of a 24-bit dividend by a 16-bit divisor.
	localparam int DIVIDEND_W = MAX_W + COLOR_W;
	localparam int DIV_STEPS  = COLOR_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	typedef struct packed {
		logic take;
		logic prep;
		logic div_step;
		logic emit_pix;
		logic emit_mask;
	} rfbw_cmd_t;

	typedef struct packed {
		logic pix_go;
		logic mask_go;
		logic mask_none;
		logic mask_more;
		logic slot_free;
	} rfbw_sts_t;

endpackage

// ===== hw/rtl/rfbw_if.sv =====
interface rfbw_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [11:0] rect_x;
	logic [11:0] rect_y;
	logic [12:0] rect_w;
	logic [12:0] rect_h;
	logic [31:0] pixel_word;
	logic [7:0]  mask_byte;

	modport source (
		output valid, mode, rect_x, rect_y, rect_w, rect_h, pixel_word, mask_byte,
		input  ready
	);
	modport sink (
		input  valid, mode, rect_x, rect_y, rect_w, rect_h, pixel_word, mask_byte,
		output ready
	);
endinterface

interface rfbw_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] pixel_address;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic        alpha_only;
	logic        last;

	modport source (
		output valid, pixel_address, red, green, blue, alpha, alpha_only, last,
		input  ready
	);
	modport sink (
		input  valid, pixel_address, red, green, blue, alpha, alpha_only, last,
		output ready
	);
endinterface

// ===== hw/rtl/rfbw_div.sv =====
module rfbw_div (
	input  logic                                clk,
	input  logic                                load,
	input  logic                                step,
	input  logic [rfbw_pkg::DIVIDEND_W-1:0]     dividend,
	input  logic [rfbw_pkg::MAX_W-1:0]          divisor,
	output logic [rfbw_pkg::COLOR_W-1:0]        quotient
);
	import rfbw_pkg::*;

	logic [MAX_W-1:0]   rem_q;
	logic [COLOR_W-1:0] low_q;
	logic [COLOR_W-1:0] quot_q;
	logic [MAX_W-1:0]   dvs_q;
	logic               zero_q;
	logic [MAX_W:0]     trial;
	logic               fits;

	// The dividend is at most 255 times the divisor, so its upper part is already
	// below the divisor and only eight quotient bits remain to be found.
	always_comb begin
		trial = {rem_q, low_q[COLOR_W-1]};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q  <= dividend[DIVIDEND_W-1:COLOR_W];
			low_q  <= dividend[COLOR_W-1:0];
			dvs_q  <= divisor;
			zero_q <= divisor == '0;
			quot_q <= '0;
		end else if (step) begin
			rem_q  <= fits ? MAX_W'(trial - {1'b0, dvs_q}) : trial[MAX_W-1:0];
			low_q  <= {low_q[COLOR_W-2:0], 1'b0};
			quot_q <= {quot_q[COLOR_W-2:0], fits};
		end
	end

	assign quotient = zero_q ? '0 : quot_q;

endmodule

// ===== hw/rtl/rfbw_ctrl.sv =====
module rfbw_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rfbw_pkg::rfbw_sts_t   sts,
	output rfbw_pkg::rfbw_cmd_t   cmd
);
	import rfbw_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PPREP = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_POUT  = 3'd3;
	localparam logic [2:0] S_MPREP = 3'd4;
	localparam logic [2:0] S_MOUT  = 3'd5;

	logic [2:0]           state_q;
	logic [2:0]           state_d;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_CNT_W-1:0] cnt_d;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.take = in_valid;
				if (in_valid && sts.pix_go) begin
					state_d = S_PPREP;
				end else if (in_valid && sts.mask_go) begin
					state_d = S_MPREP;
				end
			end
			S_PPREP: begin
				cmd.prep = 1'b1;
				cnt_d    = '0;
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = S_POUT;
				end
			end
			S_POUT: begin
				if (sts.slot_free) begin
					cmd.emit_pix = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_MPREP: begin
				cmd.prep = 1'b1;
				state_d  = sts.mask_none ? S_IDLE : S_MOUT;
			end
			S_MOUT: begin
				if (sts.slot_free) begin
					cmd.emit_mask = 1'b1;
					if (!sts.mask_more) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ===== hw/rtl/rfbw_dp.sv =====
module rfbw_dp #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  rfbw_pkg::cfg_idx_t                 cfg_index,
	input  rfbw_pkg::cfg_data_t                cfg_data,
	input  logic [rfbw_pkg::MODE_W-1:0]        mode,
	input  logic [rfbw_pkg::RECT_XY_W-1:0]     rect_x,
	input  logic [rfbw_pkg::RECT_XY_W-1:0]     rect_y,
	input  logic [rfbw_pkg::RECT_WH_W-1:0]     rect_w,
	input  logic [rfbw_pkg::RECT_WH_W-1:0]     rect_h,
	input  logic [rfbw_pkg::PIXEL_W-1:0]       pixel_word,
	input  logic [rfbw_pkg::MASK_W-1:0]        mask_byte,
	input  rfbw_pkg::rfbw_cmd_t                cmd,
	output rfbw_pkg::rfbw_sts_t                sts,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [rfbw_pkg::ADDR_W-1:0]        pixel_address,
	output logic [rfbw_pkg::COLOR_W-1:0]       red,
	output logic [rfbw_pkg::COLOR_W-1:0]       green,
	output logic [rfbw_pkg::COLOR_W-1:0]       blue,
	output logic [rfbw_pkg::COLOR_W-1:0]       alpha,
	output logic                               alpha_only,
	output logic                               last
);
	import rfbw_pkg::*;

	localparam int SW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int CW = $clog2(MAX_WIDTH + MASK_W);
	localparam int YW = $clog2((2 ** RECT_XY_W) + MAX_HEIGHT);
	localparam int PW = YW + FW_W;
	localparam int SEL_W = $clog2(MASK_W);

	// Configuration registers.
	logic [BPP_W-1:0]   bpp_q;
	logic [MAX_W-1:0]   ch_max_q   [3];
	logic [SHIFT_W-1:0] ch_shift_q [3];
	logic [FW_W-1:0]    fw_q;

	// Rectangle state.
	logic [RECT_XY_W-1:0] origin_x_q;
	logic [RECT_XY_W-1:0] origin_y_q;
	logic [SW-1:0]        span_w_q;
	logic [HW-1:0]        span_h_q;
	logic [CW-1:0]        col_q;
	logic [HW-1:0]        row_q;
	logic [YW-1:0]        cur_y_q;
	logic                 cursor_q;
	logic                 mask_phase_q;

	// Per-item working registers.
	logic [PIXEL_W-1:0] pix_q;
	logic [CW-1:0]      col_snap_q;
	logic [ADDR_W-1:0]  prod_s1;
	logic [ADDR_W-1:0]  addr_base_q;
	logic [MASK_W-1:0]  emit_q;

	logic               out_valid_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [COLOR_W-1:0] red_q;
	logic [COLOR_W-1:0] green_q;
	logic [COLOR_W-1:0] blue_q;
	logic [COLOR_W-1:0] alpha_q;
	logic               alpha_only_q;
	logic               last_q;

	logic               active;
	logic               is_header;
	logic               is_pixel;
	logic               is_mask;
	logic               advance;
	logic [CW-1:0]      col_next;
	logic [HW-1:0]      row_next;
	logic               row_done;
	logic               rect_done;
	logic [PIXEL_W-1:0] pix_masked;
	logic [MASK_W-1:0]  emit_v;
	logic [PW-1:0]      prod_full;
	logic [SEL_W-1:0]   sel_idx;
	logic [MASK_W-1:0]  sel_oh;
	logic               sel_found;
	logic [COLOR_W-1:0] quot [3];

	assign active    = (span_w_q != '0) && (row_q < span_h_q);
	assign is_header = (mode == MODE_RAW) || (mode == MODE_CURSOR);
	assign is_pixel  = (mode == MODE_PIXEL) && !mask_phase_q && active;
	assign is_mask   = (mode == MODE_MASK) && mask_phase_q && active;
	assign advance   = cmd.take && (is_pixel || is_mask);

	always_comb begin
		col_next  = col_q + (is_mask ? CW'(MASK_W) : CW'(1));
		row_next  = row_q + HW'(1);
		row_done  = col_next >= CW'(span_w_q);
		rect_done = row_next >= span_h_q;
	end

	always_comb begin
		if (bpp_q == BPP_32) begin
			pix_masked = pixel_word;
		end else if (bpp_q == BPP_16) begin
			pix_masked = {16'h0000, pixel_word[15:0]};
		end else begin
			pix_masked = {24'h000000, pixel_word[7:0]};
		end
	end

	// Mask bits to clear: a zero bit whose column lies inside the row.
	always_comb begin
		for (int i = 0; i < MASK_W; i++) begin
			emit_v[i] = ((col_q + CW'(i)) < CW'(span_w_q)) && !mask_byte[MASK_W-1-i];
		end
	end

	always_comb begin
		sel_idx   = '0;
		sel_found = 1'b0;
		for (int i = 0; i < MASK_W; i++) begin
			if (emit_q[i] && !sel_found) begin
				sel_idx   = SEL_W'(i);
				sel_found = 1'b1;
			end
		end
		sel_oh = MASK_W'(1) << sel_idx;
	end

	assign prod_full = PW'(cur_y_q) * PW'(fw_q);

	assign sts.pix_go    = is_pixel;
	assign sts.mask_go   = is_mask;
	assign sts.mask_none = emit_q == '0;
	assign sts.mask_more = (emit_q & ~sel_oh) != '0;
	assign sts.slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q         <= BPP_32;
			ch_max_q[0]   <= 16'd255;
			ch_max_q[1]   <= 16'd255;
			ch_max_q[2]   <= 16'd255;
			ch_shift_q[0] <= 5'd16;
			ch_shift_q[1] <= 5'd8;
			ch_shift_q[2] <= 5'd0;
			fw_q          <= 13'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BPP:         bpp_q         <= cfg_data[BPP_W-1:0];
				REG_RED_MAX:     ch_max_q[0]   <= cfg_data[MAX_W-1:0];
				REG_GREEN_MAX:   ch_max_q[1]   <= cfg_data[MAX_W-1:0];
				REG_BLUE_MAX:    ch_max_q[2]   <= cfg_data[MAX_W-1:0];
				REG_RED_SHIFT:   ch_shift_q[0] <= cfg_data[SHIFT_W-1:0];
				REG_GREEN_SHIFT: ch_shift_q[1] <= cfg_data[SHIFT_W-1:0];
				REG_BLUE_SHIFT:  ch_shift_q[2] <= cfg_data[SHIFT_W-1:0];
				REG_FRAME_WIDTH: fw_q          <= cfg_data[FW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			span_w_q     <= '0;
			span_h_q     <= '0;
			col_q        <= '0;
			row_q        <= '0;
			cur_y_q      <= '0;
			cursor_q     <= 1'b0;
			mask_phase_q <= 1'b0;
		end else if (cmd.take && is_header) begin
			origin_x_q   <= rect_x;
			origin_y_q   <= rect_y;
			span_w_q     <= (32'(rect_w) > MAX_WIDTH) ? SW'(MAX_WIDTH) : SW'(rect_w);
			span_h_q     <= (32'(rect_h) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(rect_h);
			col_q        <= '0;
			row_q        <= '0;
			cur_y_q      <= YW'(rect_y);
			cursor_q     <= mode == MODE_CURSOR;
			mask_phase_q <= 1'b0;
		end else if (advance) begin
			if (!row_done) begin
				col_q <= col_next;
			end else begin
				col_q <= '0;
				if (is_pixel && rect_done && cursor_q) begin
					// Last pixel of a cursor: the mask rows start over at the top.
					mask_phase_q <= 1'b1;
					row_q        <= '0;
					cur_y_q      <= YW'(origin_y_q);
				end else begin
					row_q   <= row_next;
					cur_y_q <= cur_y_q + YW'(1);
					if (is_mask && rect_done) begin
						mask_phase_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pix_q      <= pix_masked;
			col_snap_q <= col_q;
			prod_s1    <= prod_full[ADDR_W-1:0];
			emit_q     <= is_mask ? emit_v : '0;
		end else if (cmd.emit_mask) begin
			emit_q <= emit_q & ~sel_oh;
		end
		if (cmd.prep) begin
			addr_base_q <= prod_s1 + ADDR_W'(origin_x_q) + ADDR_W'(col_snap_q);
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_lane
		logic [MAX_W-1:0]      v;
		logic [DIVIDEND_W-1:0] scaled;

		assign v      = MAX_W'(pix_q >> ch_shift_q[c]) & ch_max_q[c];
		assign scaled = {v, COLOR_W'(0)} - DIVIDEND_W'(v);

		rfbw_div u_div (
			.clk      (clk),
			.load     (cmd.prep),
			.step     (cmd.div_step),
			.dividend (scaled),
			.divisor  (ch_max_q[c]),
			.quotient (quot[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_pix || cmd.emit_mask) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_pix) begin
			addr_q       <= addr_base_q;
			red_q        <= quot[0];
			green_q      <= quot[1];
			blue_q       <= quot[2];
			alpha_q      <= ALPHA_OPAQUE;
			alpha_only_q <= 1'b0;
			last_q       <= 1'b1;
		end else if (cmd.emit_mask) begin
			addr_q       <= addr_base_q + ADDR_W'(sel_idx);
			red_q        <= '0;
			green_q      <= '0;
			blue_q       <= '0;
			alpha_q      <= ALPHA_CLEAR;
			alpha_only_q <= 1'b1;
			last_q       <= !sts.mask_more;
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_address = addr_q;
	assign red           = red_q;
	assign green         = green_q;
	assign blue          = blue_q;
	assign alpha         = alpha_q;
	assign alpha_only    = alpha_only_q;
	assign last          = last_q;

endmodule

// ===== hw/rtl/rfb_raw_rect_to_rgba_writer_core.sv =====
// Converts RFB true-color raw rectangles into RGBA framebuffer writes. A header
// transfer (raw or cursor) only loads the rectangle state and yields nothing. A pixel
// transfer runs through acceptance, forming the address and loading the scaling
// lanes, eight steps of the three restoring dividers that compute floor(v*255/max),
// and the load of the output register. A cursor mask byte is accepted and prepared,
// then yields its alpha clears one at a time as the output register frees. One input
// is in flight at a time; the output register holds a finished write until the sink
// takes it. Addresses are row*frame_width+column, unclipped, modulo 2**24.
module rfb_raw_rect_to_rgba_writer_core #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  rfbw_pkg::cfg_idx_t   cfg_index,
	input  rfbw_pkg::cfg_data_t  cfg_data,
	rfbw_in_if.sink              pixel_in,
	rfbw_out_if.source           write_out
);
	import rfbw_pkg::*;

	rfbw_cmd_t cmd;
	rfbw_sts_t sts;

	rfbw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixel_in.valid),
		.in_ready (pixel_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rfbw_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mode          (pixel_in.mode),
		.rect_x        (pixel_in.rect_x),
		.rect_y        (pixel_in.rect_y),
		.rect_w        (pixel_in.rect_w),
		.rect_h        (pixel_in.rect_h),
		.pixel_word    (pixel_in.pixel_word),
		.mask_byte     (pixel_in.mask_byte),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (write_out.valid),
		.out_ready     (write_out.ready),
		.pixel_address (write_out.pixel_address),
		.red           (write_out.red),
		.green         (write_out.green),
		.blue          (write_out.blue),
		.alpha         (write_out.alpha),
		.alpha_only    (write_out.alpha_only),
		.last          (write_out.last)
	);

endmodule
